// File: hdl/cpch_pkg.sv
// Shared types, constants and helper functions of the channel pair coincidence histogram.
package cpch_pkg;

	// Matrix and event buffer geometry.
	localparam int BINS      = 32;
	localparam int MAX_HITS  = 128;
	localparam int CELLS     = BINS * BINS;
	localparam int BIN_W     = $clog2(BINS);
	localparam int CELL_W    = $clog2(CELLS);
	localparam int HIT_W     = $clog2(MAX_HITS);
	localparam int HC_W      = $clog2(MAX_HITS + 1);

	// Field widths.
	localparam int CH_W      = 12;
	localparam int OUT_CH_W  = 13;
	localparam int COUNT_W   = 32;

	localparam logic [CH_W-1:0] BASE_RESET = 12'd64;

	// Request modes.
	localparam logic MODE_HIT    = 1'b0;
	localparam logic MODE_REPORT = 1'b1;

	typedef struct packed {
		logic            mode;
		logic [CH_W-1:0] channel;
		logic            last_hit;
	} req_t;

	typedef struct packed {
		logic [OUT_CH_W-1:0] max_x_channel;
		logic [OUT_CH_W-1:0] max_y_channel;
		logic [COUNT_W-1:0]  max_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAIR,
		ST_A_WR,
		ST_B_WR,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_REPORT
	} state_t;

	// True when the channel falls inside the histogram window.
	function automatic logic win_ok(logic [CH_W-1:0] ch, logic [CH_W-1:0] base);
		logic [CH_W-1:0] diff;
		diff = ch - base;
		return (ch >= base) && (diff < CH_W'(BINS));
	endfunction

	// Bin index of a channel, valid only when win_ok holds.
	function automatic logic [BIN_W-1:0] win_idx(logic [CH_W-1:0] ch,
			logic [CH_W-1:0] base);
		logic [CH_W-1:0] diff;
		diff = ch - base;
		return diff[BIN_W-1:0];
	endfunction

	// Matrix cell address, y major.
	function automatic logic [CELL_W-1:0] cell_addr(logic [BIN_W-1:0] x,
			logic [BIN_W-1:0] y);
		return CELL_W'(y) * CELL_W'(BINS) + CELL_W'(x);
	endfunction

	// Saturating increment of a count.
	function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + COUNT_W'(1);
	endfunction

endpackage

// File: hdl/cpch_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module cpch_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port; a read of the same address in the same cycle returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/channel_pair_coincidence_histogram.sv
// Top level of the channel pair coincidence histogram.
//
// After reset the block runs a clearing pass over every cell of the count matrix
// with busy high; configuration writes are taken at any time. A hit in the window
// is paired with each earlier hit of the event that is inside the window and
// steps past each earlier hit that is not. The pace is set by the single read and
// single write port of the count memory, which each pair uses for two
// read-modify-write updates. A report request reads every cell once; its result
// appears with done for exactly one cycle, and the receiver cannot stall it.
module channel_pair_coincidence_histogram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cpch_pkg::req_t               req,
	output logic                         done,
	output cpch_pkg::res_t               result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cpch_pkg::CH_W-1:0]    cfg_data
);

	localparam int BIN_W   = cpch_pkg::BIN_W;
	localparam int CELL_W  = cpch_pkg::CELL_W;
	localparam int HIT_W   = cpch_pkg::HIT_W;
	localparam int HC_W    = cpch_pkg::HC_W;
	localparam int CH_W    = cpch_pkg::CH_W;
	localparam int COUNT_W = cpch_pkg::COUNT_W;
	localparam int OUT_W   = cpch_pkg::OUT_CH_W;

	cpch_pkg::state_t state_q, state_d;

	logic [CH_W-1:0]    base_q;
	logic [CELL_W-1:0]  clr_addr_q;
	logic [HC_W-1:0]    hit_count_q;
	logic [HC_W-1:0]    pair_end_q;
	logic [HIT_W-1:0]   k_q;
	logic [BIN_W-1:0]   n_idx_q;
	logic [BIN_W-1:0]   e_idx_q;
	logic [COUNT_W-1:0] a_new_q;
	logic [BIN_W-1:0]   scan_x_q, scan_y_q;
	logic               scan_vld_s1;
	logic [BIN_W-1:0]   scan_x_s1, scan_y_s1;
	logic [COUNT_W-1:0] best_q;
	logic [BIN_W-1:0]   bx_q, by_q;

	// Memory ports.
	logic               ev_we, ev_re;
	logic [HIT_W-1:0]   ev_waddr, ev_raddr;
	logic [CH_W-1:0]    ev_rdata;
	logic               cnt_we, cnt_re;
	logic [CELL_W-1:0]  cnt_waddr, cnt_raddr;
	logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

	logic               accept;
	logic               hit_ok;
	logic               new_ok;
	logic [BIN_W-1:0]   new_idx;
	logic               loop_go;
	logic               e_ok;
	logic [BIN_W-1:0]   e_idx_c;
	logic [HC_W-1:0]    k_next_c;
	logic               more;
	logic               scan_end;

	cpch_ram #(
		.DATA_W (CH_W),
		.DEPTH  (cpch_pkg::MAX_HITS)
	) u_event_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (req.channel),
		.re    (ev_re),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	cpch_ram #(
		.DATA_W (COUNT_W),
		.DEPTH  (cpch_pkg::CELLS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// Request decode and loop bookkeeping.
	always_comb begin
		accept   = start && !busy;
		hit_ok   = accept && (req.mode == cpch_pkg::MODE_HIT)
			&& (hit_count_q < HC_W'(cpch_pkg::MAX_HITS));
		new_ok   = cpch_pkg::win_ok(req.channel, base_q);
		new_idx  = cpch_pkg::win_idx(req.channel, base_q);
		loop_go  = hit_ok && new_ok && (hit_count_q != '0);
		e_ok     = cpch_pkg::win_ok(ev_rdata, base_q);
		e_idx_c  = cpch_pkg::win_idx(ev_rdata, base_q);
		k_next_c = HC_W'(k_q) + HC_W'(1);
		more     = k_next_c < pair_end_q;
		scan_end = (scan_x_q == BIN_W'(cpch_pkg::BINS - 1))
			&& (scan_y_q == BIN_W'(cpch_pkg::BINS - 1));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpch_pkg::ST_CLEAR: begin
				if (clr_addr_q == CELL_W'(cpch_pkg::CELLS - 1)) state_d = cpch_pkg::ST_IDLE;
			end
			cpch_pkg::ST_IDLE: begin
				if (accept && (req.mode == cpch_pkg::MODE_REPORT)) begin
					state_d = cpch_pkg::ST_SCAN;
				end else if (loop_go) begin
					state_d = cpch_pkg::ST_PAIR;
				end
			end
			cpch_pkg::ST_PAIR: begin
				if (e_ok) begin
					state_d = cpch_pkg::ST_A_WR;
				end else if (!more) begin
					state_d = cpch_pkg::ST_IDLE;
				end
			end
			cpch_pkg::ST_A_WR: state_d = cpch_pkg::ST_B_WR;
			cpch_pkg::ST_B_WR: begin
				state_d = more ? cpch_pkg::ST_PAIR : cpch_pkg::ST_IDLE;
			end
			cpch_pkg::ST_SCAN: begin
				if (scan_end) state_d = cpch_pkg::ST_SCAN_LAST;
			end
			cpch_pkg::ST_SCAN_LAST: state_d = cpch_pkg::ST_REPORT;
			cpch_pkg::ST_REPORT: state_d = cpch_pkg::ST_IDLE;
			default: state_d = cpch_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and port outputs.
	always_comb begin
		busy      = (state_q != cpch_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		done      = (state_q == cpch_pkg::ST_REPORT);
		result.max_x_channel = {1'b0, base_q} + OUT_W'(bx_q);
		result.max_y_channel = {1'b0, base_q} + OUT_W'(by_q);
		result.max_count     = best_q;

		ev_we     = hit_ok;
		ev_waddr  = hit_count_q[HIT_W-1:0];
		ev_re     = 1'b0;
		ev_raddr  = k_next_c[HIT_W-1:0];
		cnt_we    = 1'b0;
		cnt_waddr = clr_addr_q;
		cnt_wdata = '0;
		cnt_re    = 1'b0;
		cnt_raddr = cpch_pkg::cell_addr(scan_x_q, scan_y_q);

		case (state_q)
			cpch_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
			end
			cpch_pkg::ST_IDLE: begin
				// Fetch the first buffered hit of the event.
				ev_re    = loop_go;
				ev_raddr = '0;
			end
			cpch_pkg::ST_PAIR: begin
				// Read cell (x = earlier, y = new), or move past an earlier hit outside the window.
				cnt_re    = e_ok;
				cnt_raddr = cpch_pkg::cell_addr(e_idx_c, n_idx_q);
				ev_re     = !e_ok && more;
			end
			cpch_pkg::ST_A_WR: begin
				// Write the first cell back, read the mirror cell, prefetch the next hit.
				cnt_we    = 1'b1;
				cnt_waddr = cpch_pkg::cell_addr(e_idx_q, n_idx_q);
				cnt_wdata = cpch_pkg::sat_inc(cnt_rdata);
				cnt_re    = 1'b1;
				cnt_raddr = cpch_pkg::cell_addr(n_idx_q, e_idx_q);
				ev_re     = more;
			end
			cpch_pkg::ST_B_WR: begin
				// On the diagonal both updates hit one cell, so take the value just written.
				cnt_we    = 1'b1;
				cnt_waddr = cpch_pkg::cell_addr(n_idx_q, e_idx_q);
				cnt_wdata = cpch_pkg::sat_inc((e_idx_q == n_idx_q) ? a_new_q : cnt_rdata);
			end
			cpch_pkg::ST_SCAN: begin
				cnt_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpch_pkg::ST_CLEAR;
			base_q      <= cpch_pkg::BASE_RESET;
			clr_addr_q  <= '0;
			hit_count_q <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == cpch_pkg::ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (state_q == cpch_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + CELL_W'(1);
			end
			// The end mark empties the buffer even when the hit itself is dropped.
			if (accept && (req.mode == cpch_pkg::MODE_HIT)) begin
				if (req.last_hit) begin
					hit_count_q <= '0;
				end else if (hit_ok) begin
					hit_count_q <= hit_count_q + HC_W'(1);
				end
			end
		end
	end

	// Pairing loop registers.
	always_ff @(posedge clk) begin
		if (loop_go) begin
			pair_end_q <= hit_count_q;
			n_idx_q    <= new_idx;
			k_q        <= '0;
		end
		if (state_q == cpch_pkg::ST_PAIR) begin
			e_idx_q <= e_idx_c;
			if (!e_ok && more) k_q <= k_next_c[HIT_W-1:0];
		end
		if (state_q == cpch_pkg::ST_A_WR) begin
			a_new_q <= cpch_pkg::sat_inc(cnt_rdata);
		end
		if ((state_q == cpch_pkg::ST_B_WR) && more) begin
			k_q <= k_next_c[HIT_W-1:0];
		end
	end

	// Report scan: y outer, x inner, first strict maximum wins.
	always_ff @(posedge clk) begin
		scan_x_s1 <= scan_x_q;
		scan_y_s1 <= scan_y_q;
		if (accept && (req.mode == cpch_pkg::MODE_REPORT)) begin
			scan_x_q <= '0;
			scan_y_q <= '0;
			best_q   <= '0;
			bx_q     <= '0;
			by_q     <= '0;
		end else begin
			if (state_q == cpch_pkg::ST_SCAN) begin
				if (scan_x_q == BIN_W'(cpch_pkg::BINS - 1)) begin
					scan_x_q <= '0;
					scan_y_q <= scan_y_q + BIN_W'(1);
				end else begin
					scan_x_q <= scan_x_q + BIN_W'(1);
				end
			end
			if (scan_vld_s1 && (cnt_rdata > best_q)) begin
				best_q <= cnt_rdata;
				bx_q   <= scan_x_s1;
				by_q   <= scan_y_s1;
			end
		end
	end

endmodule
